/* rtl/audio_frame_ring_buffer_defines.svh */
// Assertion macros for the audio frame ring buffer.
// Included by files that carry concurrent assertions; expects clk and rst in scope.
`ifndef AUDIO_FRAME_RING_BUFFER_DEFINES_SVH
`define AUDIO_FRAME_RING_BUFFER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset.
`define AFRB_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("afrb: implication check failed");

// Holds in the cycle after reset is seen.
`define AFRB_ASSERT_AFTER_RESET(lbl, cons) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("afrb: post-reset check failed");

`else

`define AFRB_ASSERT_IMPLY(lbl, ante, cons)
`define AFRB_ASSERT_AFTER_RESET(lbl, cons)

`endif

`endif

/* rtl/afrb_pkg.sv */
// Shared constants, codes and types for the audio frame ring buffer.
// No dependencies.
package afrb_pkg;

  localparam int DEPTH       = 1024;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int MAX_BURST   = 64;
  localparam int BURST_W     = 7;
  localparam int SAMPLE_W    = 32;
  localparam int FRAME_W     = 2 * SAMPLE_W;
  localparam int UNDERRUN_W  = 32;
  localparam int FUNC_W      = 3;
  localparam int CAP_W       = 11;
  localparam int CHAN_W      = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 11;
  localparam int OP_W        = 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int Q_IDX_W     = $clog2(QUEUE_DEPTH);
  localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

  // Input function codes
  localparam logic [FUNC_W-1:0] FUNC_PUSH    = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_CONSUME = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_START   = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_STOP    = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_RESET   = 3'd4;

  // Internal command codes
  localparam logic [OP_W-1:0] OP_NOP     = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH    = 3'd1;
  localparam logic [OP_W-1:0] OP_CONSUME = 3'd2;
  localparam logic [OP_W-1:0] OP_START   = 3'd3;
  localparam logic [OP_W-1:0] OP_STOP    = 3'd4;
  localparam logic [OP_W-1:0] OP_RESET   = 3'd5;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 2'd1;

  localparam logic [CHAN_W-1:0] CHAN_MONO = 2'd1;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [SAMPLE_W-1:0] left;
    logic [SAMPLE_W-1:0] right;
    logic [BURST_W-1:0]  count;
  } cmd_t;

endpackage

/* rtl/afrb_in_if.sv */
// Input item channel of the audio frame ring buffer.
// Depends on afrb_pkg.
interface afrb_in_if import afrb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [SAMPLE_W-1:0] left_sample;
  logic [SAMPLE_W-1:0] right_sample;
  logic [BURST_W-1:0]  burst_frames;

  modport source (output valid, func, left_sample, right_sample, burst_frames, input ready);
  modport sink   (input valid, func, left_sample, right_sample, burst_frames, output ready);
endinterface

/* rtl/afrb_out_if.sv */
// Result channel of the audio frame ring buffer.
// Depends on afrb_pkg.
interface afrb_out_if import afrb_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [SAMPLE_W-1:0]   left_out;
  logic [SAMPLE_W-1:0]   right_out;
  logic                  frame_real;
  logic                  push_taken;
  logic [CNT_W-1:0]      queued_count;
  logic [UNDERRUN_W-1:0] underrun_total;
  logic                  last_of_run;

  modport source (output valid, left_out, right_out, frame_real, push_taken, queued_count,
                  underrun_total, last_of_run, input ready);
  modport sink   (input valid, left_out, right_out, frame_real, push_taken, queued_count,
                  underrun_total, last_of_run, output ready);
endinterface

/* rtl/afrb_cfg_if.sv */
// Configuration write channel of the audio frame ring buffer.
// Depends on afrb_pkg.
interface afrb_cfg_if import afrb_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/afrb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module afrb_ram #(
  parameter int WIDTH = 64,
  parameter int WORDS = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(WORDS)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(WORDS)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/afrb_cmd_queue.sv */
// Short command queue between front and back ends.
// Depends on afrb_pkg.
module afrb_cmd_queue import afrb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  cmd_t in_cmd,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t out_cmd
);

  cmd_t               entries [QUEUE_DEPTH];
  logic [Q_IDX_W-1:0] wr_ptr;
  logic [Q_IDX_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;
  logic               push;
  logic               pop;

  assign in_ready  = (count != Q_CNT_W'(QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign out_cmd   = entries[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_IDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_IDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/afrb_front.sv */
// Front end: accepts input items and turns them into back-end commands.
// Depends on afrb_pkg and afrb_in_if.
module afrb_front import afrb_pkg::*; (
  afrb_in_if.sink item_in,
  output logic    cmd_valid,
  input  logic    cmd_ready,
  output cmd_t    cmd
);

  logic [BURST_W-1:0] burst;

  // Long bursts saturate.
  assign burst = (item_in.burst_frames > BURST_W'(MAX_BURST)) ? BURST_W'(MAX_BURST)
                                                              : item_in.burst_frames;

  assign cmd_valid     = item_in.valid;
  assign item_in.ready = cmd_ready;

  always_comb begin
    cmd.left  = item_in.left_sample;
    cmd.right = item_in.right_sample;
    cmd.count = burst;
    case (item_in.func)
      FUNC_PUSH:    cmd.op = OP_PUSH;
      // empty burst is just a status result
      FUNC_CONSUME: cmd.op = (burst == '0) ? OP_NOP : OP_CONSUME;
      FUNC_START:   cmd.op = OP_START;
      FUNC_STOP:    cmd.op = OP_STOP;
      FUNC_RESET:   cmd.op = OP_RESET;
      default:      cmd.op = OP_NOP;
    endcase
  end

endmodule

/* rtl/afrb_back.sv */
// Back end: ring state, sample store access, config registers and result register.
// Depends on afrb_pkg, afrb_out_if, afrb_cfg_if and afrb_ram.
module afrb_back import afrb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  input  cmd_t       cmd,
  afrb_cfg_if.sink   cfg,
  afrb_out_if.source result_out
);

  // Ring and config state
  logic [IDX_W-1:0]      rd_idx, rd_idx_next;
  logic [IDX_W-1:0]      wr_idx, wr_idx_next;
  logic [CNT_W-1:0]      fill, fill_next;
  logic                  acc, acc_next;
  logic [UNDERRUN_W-1:0] underrun, underrun_next;
  logic [CNT_W-1:0]      eff_cap, eff_cap_next;
  logic                  mono, mono_next;

  // Burst sequencer
  logic                  busy, busy_next;
  logic [BURST_W-1:0]    rem, rem_next;
  logic [BURST_W-1:0]    real_rem, real_rem_next;

  // Result register
  logic                  o_valid;
  logic                  o_real;
  logic                  o_taken;
  logic                  o_last;
  logic [CNT_W-1:0]      o_queued;
  logic [UNDERRUN_W-1:0] o_underrun;

  logic                  can_issue, start, step, issue;
  logic                  n_real, n_taken, n_last;
  logic [BURST_W-1:0]    real_cnt;
  logic [CAP_W-1:0]      cap_in;

  logic                  re, we;
  logic [FRAME_W-1:0]    wdata, rdata;

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx,
                                               input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] n;
    n = CNT_W'(idx) + 1'b1;
    return (n >= cap) ? '0 : n[IDX_W-1:0];
  endfunction

  assign can_issue = !o_valid || result_out.ready;
  assign cmd_ready = !busy && can_issue;
  assign start     = cmd_valid && cmd_ready;
  assign step      = busy && can_issue;
  assign cfg.ready = 1'b1;

  assign real_cnt = (CNT_W'(cmd.count) < fill) ? cmd.count : fill[BURST_W-1:0];
  assign cap_in   = cfg.data[CAP_W-1:0];
  assign wdata    = mono ? {{SAMPLE_W{1'b0}}, cmd.left} : {cmd.right, cmd.left};

  always_comb begin
    rd_idx_next   = rd_idx;
    wr_idx_next   = wr_idx;
    fill_next     = fill;
    acc_next      = acc;
    underrun_next = underrun;
    eff_cap_next  = eff_cap;
    mono_next     = mono;
    busy_next     = busy;
    rem_next      = rem;
    real_rem_next = real_rem;
    issue         = 1'b0;
    n_real        = 1'b0;
    n_taken       = 1'b0;
    n_last        = 1'b1;
    re            = 1'b0;
    we            = 1'b0;

    if (start) begin
      issue = 1'b1;
      case (cmd.op)
        OP_PUSH: begin
          if (acc && (fill < eff_cap)) begin
            we          = 1'b1;
            wr_idx_next = idx_inc(wr_idx, eff_cap);
            fill_next   = fill + 1'b1;
            n_taken     = 1'b1;
          end
        end
        OP_CONSUME: begin
          // first frame is read from the store in the same cycle the burst starts
          if ((real_cnt < cmd.count) && acc) begin
            underrun_next = underrun + 1'b1;
          end
          n_last        = (cmd.count == BURST_W'(1));
          busy_next     = !n_last;
          rem_next      = cmd.count - 1'b1;
          real_rem_next = real_cnt;
          if (real_cnt != '0) begin
            re            = 1'b1;
            n_real        = 1'b1;
            rd_idx_next   = idx_inc(rd_idx, eff_cap);
            fill_next     = fill - 1'b1;
            real_rem_next = real_cnt - 1'b1;
          end
        end
        OP_START: acc_next = 1'b1;
        OP_STOP: begin
          acc_next    = 1'b0;
          rd_idx_next = wr_idx;
          fill_next   = '0;
        end
        OP_RESET: begin
          rd_idx_next   = '0;
          wr_idx_next   = '0;
          fill_next     = '0;
          acc_next      = 1'b0;
          underrun_next = '0;
        end
        default: ;
      endcase
    end else if (step) begin
      issue     = 1'b1;
      n_last    = (rem == BURST_W'(1));
      busy_next = !n_last;
      rem_next  = rem - 1'b1;
      if (real_rem != '0) begin
        re            = 1'b1;
        n_real        = 1'b1;
        rd_idx_next   = idx_inc(rd_idx, eff_cap);
        fill_next     = fill - 1'b1;
        real_rem_next = real_rem - 1'b1;
      end
    end

    // config writes must arrive only while idle (the block does not enforce it); both flush the ring
    if (cfg.valid) begin
      if (cfg.index == CFG_CAPACITY) begin
        if (cap_in == '0) begin
          eff_cap_next = CNT_W'(1);
        end else if (CNT_W'(cap_in) > CNT_W'(DEPTH)) begin
          eff_cap_next = CNT_W'(DEPTH);
        end else begin
          eff_cap_next = CNT_W'(cap_in);
        end
        rd_idx_next = '0;
        wr_idx_next = '0;
        fill_next   = '0;
      end else if (cfg.index == CFG_CHANNELS) begin
        mono_next   = (cfg.data[CHAN_W-1:0] == CHAN_MONO);
        rd_idx_next = '0;
        wr_idx_next = '0;
        fill_next   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx   <= '0;
      wr_idx   <= '0;
      fill     <= '0;
      acc      <= 1'b0;
      underrun <= '0;
      eff_cap  <= CNT_W'(DEPTH);
      mono     <= 1'b0;
      busy     <= 1'b0;
      o_valid  <= 1'b0;
    end else begin
      rd_idx   <= rd_idx_next;
      wr_idx   <= wr_idx_next;
      fill     <= fill_next;
      acc      <= acc_next;
      underrun <= underrun_next;
      eff_cap  <= eff_cap_next;
      mono     <= mono_next;
      busy     <= busy_next;
      if (issue) begin
        o_valid <= 1'b1;
      end else if (result_out.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem      <= rem_next;
    real_rem <= real_rem_next;
    if (issue) begin
      o_real     <= n_real;
      o_taken    <= n_taken;
      o_last     <= n_last;
      o_queued   <= fill_next;
      o_underrun <= underrun_next;
    end
  end

  afrb_ram #(
    .WIDTH (FRAME_W),
    .WORDS (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (wr_idx),
    .wdata (wdata),
    .re    (re),
    .raddr (rd_idx),
    .rdata (rdata)
  );

  // read data is held by the RAM while no new read is issued
  assign result_out.valid          = o_valid;
  assign result_out.left_out       = o_real ? rdata[SAMPLE_W-1:0] : '0;
  assign result_out.right_out      = o_real ? rdata[FRAME_W-1:SAMPLE_W] : '0;
  assign result_out.frame_real     = o_real;
  assign result_out.push_taken     = o_taken;
  assign result_out.queued_count   = o_queued;
  assign result_out.underrun_total = o_underrun;
  assign result_out.last_of_run    = o_last;

endmodule

/* rtl/audio_frame_ring_buffer.sv */
// Top level of the audio frame ring buffer: front end, command queue, back end.
// Depends on afrb_pkg, the channel interfaces, afrb_front, afrb_cmd_queue, afrb_back.
//
// FIFO of audio frames (one or two 32-bit words, stored as raw bits) in a
// 1024-entry single-port-read store. Items enter on item_in; the front end
// decodes them (long bursts saturate to 64 frames, empty bursts and unknown
// codes become status-only) and drops them into a two-entry command queue, so
// up to two input transfers are taken while the back end works or the result
// side stalls. The back end runs one command at a time. A push, a start/stop,
// a reset command or an empty burst produces one result. A consume burst of N
// frames produces N results, one per cycle while the result side is ready,
// since each ring frame costs one read of the store. The back end takes the
// command at the head of the queue once it is idle and its result register is
// free; the store read and the result register load at the edge that takes
// it, so the first result is presented right after that edge. Frames
// come from the ring while it holds data, silence (frame_real low, zero
// samples) fills the rest, and a short burst while accepting bumps the
// underrun count once, visible on all of that burst's results. queued_count
// is the fill after each result. Writes on cfg are taken every cycle, must
// only be issued while the block is idle, and, to registers 0 and 1, flush the
// ring (accepting flag and underrun count are kept). Register 0 is the capacity
// (0 acts as 1, above 1024 acts as 1024), register 1 the channel count (1 is
// mono, anything else stereo). The store needs no clearing pass after reset:
// the fill level guards every read.
`include "audio_frame_ring_buffer_defines.svh"

module audio_frame_ring_buffer import afrb_pkg::*; (
  input logic        clk,
  input logic        rst,
  afrb_in_if.sink    item_in,
  afrb_cfg_if.sink   cfg,
  afrb_out_if.source result_out
);

  // front end -> queue
  logic fq_valid;
  logic fq_ready;
  cmd_t fq_cmd;

  // queue -> back end
  logic qb_valid;
  logic qb_ready;
  cmd_t qb_cmd;

  afrb_front u_front (
    .item_in   (item_in),
    .cmd_valid (fq_valid),
    .cmd_ready (fq_ready),
    .cmd       (fq_cmd)
  );

  afrb_cmd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_cmd    (fq_cmd),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_cmd   (qb_cmd)
  );

  afrb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (qb_valid),
    .cmd_ready  (qb_ready),
    .cmd        (qb_cmd),
    .cfg        (cfg),
    .result_out (result_out)
  );

  // A frame read from the ring never comes from a push command.
  `AFRB_ASSERT_IMPLY(a_real_not_push, result_out.valid && result_out.frame_real,
                     !result_out.push_taken)
  // Reading a frame leaves the ring short of full.
  `AFRB_ASSERT_IMPLY(a_real_below_depth, result_out.valid && result_out.frame_real,
                     result_out.queued_count < CNT_W'(DEPTH))
  // Fill never exceeds the store.
  `AFRB_ASSERT_IMPLY(a_fill_in_range, result_out.valid,
                     result_out.queued_count <= CNT_W'(DEPTH))
  // Nothing is left in flight after reset.
  `AFRB_ASSERT_AFTER_RESET(a_idle_after_reset, !result_out.valid && !qb_valid)

endmodule

/* test/testbench.sv */
// Self-checking testbench for audio_frame_ring_buffer: a directed table, then random phases.
// Depends on afrb_pkg, the afrb_in_if/afrb_cfg_if/afrb_out_if interfaces and the block itself.
// Results are compared, in order, against a frame-accurate prediction of the ring.
module testbench;
  import afrb_pkg::*;

  // Register settle time before a write, and idle cycles after the last result
  localparam int SETTLE_CYCLES = 4;
  // Cycles without any transfer on any channel before the run is declared hung
  localparam int STALL_LIMIT   = 3000;
  localparam int RANDOM_ITEMS  = 345;

  // Function codes the block does not decode; they only produce a status result
  localparam logic [FUNC_W-1:0]    FUNC_UNUSED_LO = 3'd5;
  localparam logic [FUNC_W-1:0]    FUNC_UNUSED_HI = 3'd7;
  // Register indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI  = 2'd3;

  // One result transfer as the block should present it
  typedef struct packed {
    logic [SAMPLE_W-1:0]   left;
    logic [SAMPLE_W-1:0]   right;
    logic                  from_ring;
    logic                  taken;
    logic [CNT_W-1:0]      queued;
    logic [UNDERRUN_W-1:0] under;
    logic                  last;
  } frame_result_t;

  // One row of the directed table: either a register write or an input item.
  // Rows marked typed carry their single status result written out by hand.
  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    logic [FUNC_W-1:0]     func;
    logic [SAMPLE_W-1:0]   left;
    logic [SAMPLE_W-1:0]   right;
    logic [BURST_W-1:0]    count;
    bit                    typed;
    bit                    taken;
    logic [CNT_W-1:0]      queued;
    logic [UNDERRUN_W-1:0] under;
  } step_row_t;

  logic clk = 1'b0;
  logic rst;

  afrb_in_if  item_ch ();
  afrb_cfg_if cfg_ch ();
  afrb_out_if res_ch ();

  audio_frame_ring_buffer i_dut (
    .clk        (clk),
    .rst        (rst),
    .item_in    (item_ch),
    .cfg        (cfg_ch),
    .result_out (res_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Ring prediction. Shadow copy of the store, pointers, fill, flag, counter and
  // both registers. Pointers wrap at the usable capacity, not at DEPTH.
  // ---------------------------------------------------------------------------
  logic [FRAME_W-1:0]    ring_mem [DEPTH];
  int                    rd_ptr;
  int                    wr_ptr;
  int                    fill;
  bit                    accepting;
  logic [UNDERRUN_W-1:0] under_cnt;
  logic [CAP_W-1:0]      cap_reg;
  logic [CHAN_W-1:0]     chan_reg;

  frame_result_t expected_frames [$];
  int            mismatches = 0;

  // capacity 0 behaves as 1, anything past DEPTH as DEPTH
  function automatic int usable_frames();
    if (cap_reg == 0) return 1;
    if (cap_reg > DEPTH) return DEPTH;
    return int'(cap_reg);
  endfunction

  function automatic int next_slot(input int p);
    return (p + 1 >= usable_frames()) ? 0 : p + 1;
  endfunction

  function automatic void flush_ring();
    rd_ptr = 0;
    wr_ptr = 0;
    fill   = 0;
  endfunction

  // queued and under are taken from the state at the moment the result is formed
  function automatic void note_result(input logic [SAMPLE_W-1:0] l, input logic [SAMPLE_W-1:0] r,
                                      input bit from_ring, input bit taken, input bit last);
    frame_result_t res;
    res = '{left: l, right: r, from_ring: from_ring, taken: taken,
            queued: fill[CNT_W-1:0], under: under_cnt, last: last};
    expected_frames.push_back(res);
  endfunction

  function automatic void predict_frames(input logic [FUNC_W-1:0] f,
                                         input logic [SAMPLE_W-1:0] l,
                                         input logic [SAMPLE_W-1:0] r,
                                         input logic [BURST_W-1:0] n);
    int                 want;
    int                 nreal;
    bit                 mono;
    bit                 take;
    logic [FRAME_W-1:0] word;
    mono = (chan_reg == CHAN_MONO);
    case (f)
      FUNC_PUSH: begin
        take = accepting && (fill < usable_frames());
        if (take) begin
          ring_mem[wr_ptr] = mono ? {{SAMPLE_W{1'b0}}, l} : {r, l};
          wr_ptr = next_slot(wr_ptr);
          fill++;
        end
        note_result('0, '0, 1'b0, take, 1'b1);
      end
      FUNC_CONSUME: begin
        want = (n > MAX_BURST) ? MAX_BURST : int'(n);
        if (want == 0) begin
          // empty burst: status only, never an underrun
          note_result('0, '0, 1'b0, 1'b0, 1'b1);
        end else begin
          nreal = (want < fill) ? want : fill;
          // one count per short burst, and only while accepting
          if (nreal < want && accepting) under_cnt++;
          for (int k = 0; k < want; k++) begin
            if (k < nreal) begin
              word = ring_mem[rd_ptr];
              rd_ptr = next_slot(rd_ptr);
              fill--;
              note_result(word[SAMPLE_W-1:0], mono ? '0 : word[FRAME_W-1:SAMPLE_W],
                          1'b1, 1'b0, k == want - 1);
            end else begin
              note_result('0, '0, 1'b0, 1'b0, k == want - 1);
            end
          end
        end
      end
      FUNC_START: begin
        accepting = 1'b1;
        note_result('0, '0, 1'b0, 1'b0, 1'b1);
      end
      FUNC_STOP: begin
        // flush by moving read up to write
        accepting = 1'b0;
        rd_ptr = wr_ptr;
        fill = 0;
        note_result('0, '0, 1'b0, 1'b0, 1'b1);
      end
      FUNC_RESET: begin
        flush_ring();
        accepting = 1'b0;
        under_cnt = '0;
        note_result('0, '0, 1'b0, 1'b0, 1'b1);
      end
      default: begin
        note_result('0, '0, 1'b0, 1'b0, 1'b1);
      end
    endcase
  endfunction

  // Either register write flushes the ring; flag and counter survive
  function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] val);
    if (idx == CFG_CAPACITY) begin
      cap_reg = val[CAP_W-1:0];
      flush_ring();
    end else if (idx == CFG_CHANNELS) begin
      chan_reg = val[CHAN_W-1:0];
      flush_ring();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Idle gaps: mostly short, now and then a long one. The source also
  // runs calm stretches with back-to-back transfers.
  // ---------------------------------------------------------------------------
  int src_calm = 0;

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  function automatic int src_gap();
    if (src_calm > 0) begin
      src_calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      src_calm = $urandom_range(10, 40);
      return 0;
    end
    if ($urandom_range(0, 1) == 0) return 0;
    return gap_len();
  endfunction

  // Result side: alternating ready/stall runs, occasionally a long ready run
  int sink_run = 0;
  bit sink_on  = 1'b0;

  always @(posedge clk) begin
    if (sink_run == 0) begin
      sink_on  = !sink_on;
      sink_run = sink_on ? (($urandom_range(0, 9) == 0) ? $urandom_range(40, 150)
                                                        : $urandom_range(1, 12))
                         : gap_len();
    end
    sink_run = sink_run - 1;
    res_ch.ready <= sink_on;
  end

  // ---------------------------------------------------------------------------
  // Drivers. Both hold valid until the transfer happens; the prediction is
  // updated in the time step of the input transfer.
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic [FUNC_W-1:0] f, input logic [SAMPLE_W-1:0] l,
                           input logic [SAMPLE_W-1:0] r, input logic [BURST_W-1:0] n);
    int gap;
    gap = src_gap();
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid        <= 1'b1;
    item_ch.func         <= f;
    item_ch.left_sample  <= l;
    item_ch.right_sample <= r;
    item_ch.burst_frames <= n;
    do @(posedge clk); while (!item_ch.ready);
    predict_frames(f, l, r, n);
  endtask

  // Register writes only once the block has drained every expected result
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    item_ch.valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    apply_register(idx, val);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: every result transfer against the oldest expectation
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    frame_result_t want_res;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_frames.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual left %h right %h last %b",
                 $time, res_ch.left_out, res_ch.right_out, res_ch.last_of_run);
        mismatches++;
      end else begin
        want_res = expected_frames.pop_front();
        check_field("left_out",       want_res.left,      res_ch.left_out);
        check_field("right_out",      want_res.right,     res_ch.right_out);
        check_field("frame_real",     32'(want_res.from_ring), 32'(res_ch.frame_real));
        check_field("push_taken",     32'(want_res.taken),     32'(res_ch.push_taken));
        check_field("queued_count",   32'(want_res.queued),    32'(res_ch.queued_count));
        check_field("underrun_total", want_res.under,     res_ch.underrun_total);
        check_field("last_of_run",    32'(want_res.last),      32'(res_ch.last_of_run));
      end
    end
  end

  // Watchdog: any transfer on any channel restarts the count
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((item_ch.valid && item_ch.ready) || (cfg_ch.valid && cfg_ch.ready) ||
        (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("testbench: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Directed table helpers
  // ---------------------------------------------------------------------------
  function automatic step_row_t item_row(input logic [FUNC_W-1:0] f,
                                         input logic [SAMPLE_W-1:0] l,
                                         input logic [SAMPLE_W-1:0] r,
                                         input int n);
    step_row_t row;
    row = '{default: '0};
    row.func  = f;
    row.left  = l;
    row.right = r;
    row.count = BURST_W'(n);
    return row;
  endfunction

  // Single-result row with its status typed in: push_taken, queued_count, underrun_total
  function automatic step_row_t status_row(input logic [FUNC_W-1:0] f,
                                           input logic [SAMPLE_W-1:0] l,
                                           input logic [SAMPLE_W-1:0] r,
                                           input int n, input int taken,
                                           input int queued, input int under);
    step_row_t row;
    row = item_row(f, l, r, n);
    row.typed  = 1'b1;
    row.taken  = (taken != 0);
    row.queued = CNT_W'(queued);
    row.under  = UNDERRUN_W'(under);
    return row;
  endfunction

  function automatic step_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input int val);
    step_row_t row;
    row = '{default: '0};
    row.is_cfg  = 1'b1;
    row.reg_idx = idx;
    row.reg_val = CFG_DATA_W'(val);
    return row;
  endfunction

  // Capacity per random phase: mostly small rings so they fill and wrap,
  // plus the edges (0 acting as 1, 1, 1024, 2047 acting as 1024) and anything
  function automatic logic [CAP_W-1:0] pick_capacity();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return CAP_W'(1);
      2:       return CAP_W'(DEPTH);
      3:       return '1;
      4:       return CAP_W'($urandom_range(0, 2047));
      default: return CAP_W'($urandom_range(2, 12));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    step_row_t         plan [$];
    frame_result_t     typed_res;
    int                random_items;
    int                phase_len;
    int                push_pct;
    int                pick;
    bit                fill_phase;
    logic [FUNC_W-1:0] f;
    logic [BURST_W-1:0] n;

    // State after reset: default capacity and stereo, ring empty, not accepting
    flush_ring();
    accepting = 1'b0;
    under_cnt = '0;
    cap_reg   = CAP_W'(DEPTH);
    chan_reg  = 2'd2;

    rst                  = 1'b1;
    item_ch.valid        = 1'b0;
    item_ch.func         = FUNC_PUSH;
    item_ch.left_sample  = '0;
    item_ch.right_sample = '0;
    item_ch.burst_frames = '0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = CFG_CAPACITY;
    cfg_ch.data          = '0;
    res_ch.ready         = 1'b0;

    plan = '{
      // fresh out of reset: not accepting, so push refused and burst is silence
      status_row(FUNC_PUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0),
      item_row(FUNC_CONSUME, 0, 0, 3),
      status_row(FUNC_CONSUME, 0, 0, 0, 0, 0, 0),                  // empty burst
      status_row(FUNC_UNUSED_LO, 32'hFFFF_FFFF, 0, 127, 0, 0, 0),
      status_row(FUNC_START, 0, 0, 0, 0, 0, 0),
      status_row(FUNC_PUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 127, 1, 1, 0),
      status_row(FUNC_PUSH, 0, 0, 0, 1, 2, 0),
      status_row(FUNC_PUSH, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 0, 1, 3, 0),
      item_row(FUNC_CONSUME, 0, 0, 4),                              // short by one
      item_row(FUNC_CONSUME, 0, 0, 127),                            // saturates to 64
      item_row(FUNC_CONSUME, 0, 0, MAX_BURST),
      status_row(FUNC_PUSH, 32'h1234_5678, 32'h9ABC_DEF0, 0, 1, 1, 3),
      status_row(FUNC_STOP, 0, 0, 0, 0, 0, 3),                     // flush
      status_row(FUNC_PUSH, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 0, 0, 0, 3),
      item_row(FUNC_CONSUME, 0, 0, 1),                              // silence, no count
      status_row(FUNC_UNUSED_HI, 0, 32'hFFFF_FFFF, 0, 0, 0, 3),
      status_row(FUNC_RESET, 0, 0, 0, 0, 0, 0),
      // capacity 0 acts as a one-frame ring, mono
      cfg_row(CFG_CAPACITY, 0),
      cfg_row(CFG_CHANNELS, int'(CHAN_MONO)),
      status_row(FUNC_START, 0, 0, 0, 0, 0, 0),
      status_row(FUNC_PUSH, 32'hDEAD_BEEF, 32'hCAFE_F00D, 0, 1, 1, 0),
      status_row(FUNC_PUSH, 32'h1111_1111, 32'h2222_2222, 0, 0, 1, 0), // full
      item_row(FUNC_CONSUME, 0, 0, 2),
      // capacity past DEPTH clamps, channel code 3 is stereo; flag and count kept
      cfg_row(CFG_CAPACITY, 2047),
      cfg_row(CFG_CHANNELS, 3),
      status_row(FUNC_PUSH, 32'h8765_4321, 32'hFEDC_BA98, 0, 1, 1, 1),
      item_row(FUNC_CONSUME, 0, 0, 1)
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        send_item(plan[i].func, plan[i].left, plan[i].right, plan[i].count);
        if (plan[i].typed) begin
          typed_res = '{left: '0, right: '0, from_ring: 1'b0, taken: plan[i].taken,
                        queued: plan[i].queued, under: plan[i].under, last: 1'b1};
          expected_frames[expected_frames.size() - 1] = typed_res;
        end
      end
    end

    // Random phases: fresh register settings, then a run of items. Fill phases
    // push hard and drain slowly so the ring reaches full and wraps.
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 4) != 0) write_reg(CFG_CAPACITY, pick_capacity());
      if ($urandom_range(0, 2) != 0)
        write_reg(CFG_CHANNELS, CFG_DATA_W'($urandom_range(0, 3)));
      if ($urandom_range(0, 7) == 0)
        write_reg(CFG_IDX_W'($urandom_range(CFG_UNUSED_LO, CFG_UNUSED_HI)),
                  CFG_DATA_W'($urandom));

      fill_phase = ($urandom_range(0, 2) == 0);
      push_pct   = fill_phase ? 75 : $urandom_range(35, 60);
      phase_len  = $urandom_range(25, 60);

      if ($urandom_range(0, 3) != 0) begin
        send_item(FUNC_START, $urandom, $urandom, BURST_W'($urandom));
        random_items++;
      end

      repeat (phase_len) begin
        if (random_items >= RANDOM_ITEMS) break;
        pick = $urandom_range(0, 99);
        if (pick < push_pct)       f = FUNC_PUSH;
        else if (pick < 88)        f = FUNC_CONSUME;
        else if (pick < 93)        f = FUNC_START;
        else if (pick < 96)        f = FUNC_STOP;
        else if (pick < 98)        f = FUNC_RESET;
        else                       f = FUNC_W'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI));

        pick = $urandom_range(0, 99);
        if (fill_phase)            n = BURST_W'($urandom_range(1, 2));
        else if (pick < 5)         n = '0;
        else if (pick < 8)         n = BURST_W'($urandom_range(MAX_BURST + 1, 127));
        else if (pick < 14)        n = BURST_W'($urandom_range(5, MAX_BURST));
        else                       n = BURST_W'($urandom_range(1, 4));

        send_item(f, $urandom, $urandom, n);
        random_items++;
      end
    end

    // Drain, then give the block a few idle cycles to show any stray result
    item_ch.valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
